### rtl/core/mts_pkg.sv
// Package with the opcode, status and sequencer state types of the max-tracking stack.
`timescale 1ns / 1ps
package mts_pkg;

	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_POP     = 2'd1,
		OP_EXTRACT = 2'd2,
		OP_SORT    = 2'd3
	} mts_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} mts_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH_WAIT,
		S_POP_WAIT,
		S_SCAN_WAIT,
		S_PREV_WAIT,
		S_SHIFT_RD,
		S_SHIFT_WAIT,
		S_SORT_RD,
		S_SORT_LOAD,
		S_CMP_WAIT,
		S_SORT_PUT,
		S_FILL_WAIT,
		S_FILL,
		S_DONE
	} mts_state_t;

	typedef logic signed [31:0] mts_word_t;

endpackage

### rtl/core/max_tracking_stack.sv
// Top level of the max-tracking stack: sequencer, output register and two state memories.
//
//   channel | signals                                   | beat accepted when
//   --------+-------------------------------------------+----------------------------
//   input   | opcode, push_value                        | in_valid && in_ready
//   output  | result_value, stack_empty, status,        | out_valid && out_ready
//           | entries_held                              |
//
// Push and pop each use one memory read; a push onto an empty or full stack and a pop
// or extract on an empty stack go straight to the result. Extract-max scans down one
// entry a cycle from the top, then shifts the entries above the found one through the
// single read port, with a read state and a write state per entry. Sort is an insertion
// sort on the value memory, followed by a pass rewriting the running maximums. Reset
// empties the stack at once; memory contents are not cleared. A new beat is taken
// whenever the sequencer is idle; a finished result waits in the output register while
// the next item is worked on.
`timescale 1ns / 1ps
module max_tracking_stack
	import mts_pkg::*;
#(
	parameter int STACK_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] push_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic               stack_empty,
	output logic [1:0]         status,
	output logic [8:0]         entries_held
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] ONE  = CW'(1);

	mts_state_t  state_q, state_d;
	mts_op_t     op_c;
	logic [CW-1:0] count_q, idx_q, j_q;
	mts_word_t   pv_q, res_q, prev_q, v_q;
	mts_status_t st_q;

	logic        accept;
	logic [CW-1:0] rd_idx;
	logic        v_we, m_we;
	logic [CW-1:0] v_widx, m_widx;
	mts_word_t   v_wd, m_wd;
	logic [31:0] v_rd_raw, m_rd_raw;
	mts_word_t   v_rd, m_rd, shift_max;
	logic        out_load;

	assign op_c     = mts_op_t'(opcode);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign v_rd     = $signed(v_rd_raw);
	assign m_rd     = $signed(m_rd_raw);
	assign shift_max = (idx_q == '0 || v_rd > prev_q) ? v_rd : prev_q;
	assign out_load = (state_q == S_DONE) && (!out_valid || out_ready);

	mts_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_widx[AW-1:0]),
		.wdata (v_wd),
		.raddr (rd_idx[AW-1:0]),
		.rdata (v_rd_raw)
	);

	mts_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_max_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_widx[AW-1:0]),
		.wdata (m_wd),
		.raddr (rd_idx[AW-1:0]),
		.rdata (m_rd_raw)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_c)
						OP_PUSH:    state_d = (count_q == FULL || count_q == '0) ?
							S_DONE : S_PUSH_WAIT;
						OP_POP:     state_d = (count_q == '0) ? S_DONE : S_POP_WAIT;
						OP_EXTRACT: state_d = (count_q == '0) ? S_DONE : S_SCAN_WAIT;
						default:    state_d = (count_q <= ONE) ? S_DONE : S_SORT_RD;
					endcase
				end
			end
			S_PUSH_WAIT, S_POP_WAIT: state_d = S_DONE;
			S_SCAN_WAIT: begin
				if (v_rd == m_rd || idx_q == '0) begin
					state_d = (idx_q == '0) ? S_SHIFT_RD : S_PREV_WAIT;
				end
			end
			S_PREV_WAIT: state_d = S_SHIFT_RD;
			S_SHIFT_RD:  state_d = (idx_q + ONE < count_q) ? S_SHIFT_WAIT : S_DONE;
			S_SHIFT_WAIT: state_d = S_SHIFT_RD;
			S_SORT_RD:   state_d = (idx_q < count_q) ? S_SORT_LOAD : S_FILL_WAIT;
			S_SORT_LOAD: state_d = S_CMP_WAIT;
			S_CMP_WAIT: begin
				if (!(v_q > v_rd) || j_q == ONE) begin
					state_d = S_SORT_PUT;
				end
			end
			S_SORT_PUT:  state_d = S_SORT_RD;
			S_FILL_WAIT: state_d = S_FILL;
			S_FILL:      state_d = (idx_q + ONE == count_q) ? S_DONE : S_FILL;
			S_DONE:      state_d = out_load ? S_IDLE : S_DONE;
			default:     state_d = S_IDLE;
		endcase
	end

	// Memory port controls.
	always_comb begin
		rd_idx = '0;
		v_we   = 1'b0;
		m_we   = 1'b0;
		v_widx = idx_q;
		m_widx = idx_q;
		v_wd   = v_rd;
		m_wd   = shift_max;
		case (state_q)
			S_IDLE: begin
				rd_idx = count_q - ONE;
				if (accept && op_c == OP_PUSH && count_q == '0) begin
					v_we   = 1'b1;
					m_we   = 1'b1;
					v_widx = '0;
					m_widx = '0;
					v_wd   = push_value;
					m_wd   = push_value;
				end
			end
			S_PUSH_WAIT: begin
				v_we   = 1'b1;
				m_we   = 1'b1;
				v_widx = count_q;
				m_widx = count_q;
				v_wd   = pv_q;
				m_wd   = (m_rd > pv_q) ? m_rd : pv_q;
			end
			S_SCAN_WAIT:  rd_idx = idx_q - ONE;
			S_SHIFT_RD:   rd_idx = idx_q + ONE;
			S_SHIFT_WAIT: begin
				v_we = 1'b1;
				m_we = 1'b1;
			end
			S_SORT_RD:   rd_idx = (idx_q < count_q) ? idx_q : '0;
			S_SORT_LOAD: rd_idx = j_q - ONE;
			S_CMP_WAIT: begin
				rd_idx = j_q - CW'(2);
				if (v_q > v_rd) begin
					v_we   = 1'b1;
					v_widx = j_q;
				end
			end
			S_SORT_PUT: begin
				v_we   = 1'b1;
				v_widx = j_q;
				v_wd   = v_q;
			end
			S_FILL: begin
				m_we = 1'b1;
				m_wd = prev_q;
			end
			default: rd_idx = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (accept && op_c == OP_PUSH && count_q == '0) begin
				count_q <= ONE;
			end
			case (state_q)
				S_PUSH_WAIT: count_q <= count_q + ONE;
				S_POP_WAIT:  count_q <= count_q - ONE;
				S_SHIFT_RD: begin
					if (!(idx_q + ONE < count_q)) begin
						count_q <= count_q - ONE;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pv_q  <= push_value;
				res_q <= '0;
				idx_q <= (op_c == OP_SORT) ? ONE : count_q - ONE;
				if (op_c == OP_PUSH && count_q == FULL) begin
					st_q <= ST_OVER;
				end else if ((op_c == OP_POP || op_c == OP_EXTRACT) && count_q == '0) begin
					st_q <= ST_UNDER;
				end else begin
					st_q <= ST_OK;
				end
			end
			S_POP_WAIT: res_q <= v_rd;
			S_SCAN_WAIT: begin
				if (v_rd == m_rd || idx_q == '0) begin
					res_q <= v_rd;
				end else begin
					idx_q <= idx_q - ONE;
				end
			end
			S_PREV_WAIT: prev_q <= m_rd;
			S_SHIFT_WAIT: begin
				prev_q <= shift_max;
				idx_q  <= idx_q + ONE;
			end
			S_SORT_RD: j_q <= idx_q;
			S_SORT_LOAD: v_q <= v_rd;
			S_CMP_WAIT: begin
				if (v_q > v_rd) begin
					j_q <= j_q - ONE;
				end
			end
			S_SORT_PUT: idx_q <= idx_q + ONE;
			S_FILL_WAIT: begin
				// After sorting, the bottom entry is the maximum of every prefix.
				prev_q <= v_rd;
				idx_q  <= '0;
			end
			S_FILL: idx_q <= idx_q + ONE;
			default: ;
		endcase
		if (out_load) begin
			result_value <= res_q;
			stack_empty  <= (count_q == '0);
			status       <= st_q;
			entries_held <= 9'(count_q);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL) else $error("fill count above depth");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready) else $error("sequencer stayed idle after a beat");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid && in_ready) else $error("result not presented");

	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && st_q == ST_OVER |-> count_q == FULL) else $error("overflow below full");

endmodule

### rtl/core/mts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module mts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### tb/tb_max_tracking_stack.sv
// Self-checking testbench for the max-tracking stack: random and directed operations.
`timescale 1ns / 1ps
module tb_max_tracking_stack;
	import mts_pkg::*;

	localparam int DEPTH = 256;
	localparam int IDLE_LIMIT = 400000;

	typedef struct packed {
		mts_op_t   op;
		mts_word_t val;
	} stack_cmd_t;

	typedef struct packed {
		mts_word_t   val;
		logic        empty;
		mts_status_t st;
		logic [8:0]  held;
	} stack_resp_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  opcode;
	mts_word_t   push_value;
	logic        out_valid;
	logic        out_ready;
	mts_word_t   result_value;
	logic        stack_empty;
	logic [1:0]  status;
	logic [8:0]  entries_held;

	max_tracking_stack #(.STACK_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .push_value(push_value), .out_valid(out_valid),
		.out_ready(out_ready), .result_value(result_value), .stack_empty(stack_empty),
		.status(status), .entries_held(entries_held)
	);

	stack_cmd_t  pending_cmds[$];
	stack_resp_t expected_resps[$];
	mts_word_t   shadow_vals[DEPTH];
	int          shadow_fill;
	int          mismatches;
	int          idle_cycles;
	int          gap_in;
	int          gap_out;
	int          in_count;
	int          sim_fill;
	logic        in_ready_seen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Applies one operation to the shadow stack and returns the response it should give.
	// Only values are kept; the maximum is found by a scan, which is equivalent.
	function automatic stack_resp_t apply_stack_op(stack_cmd_t c);
		stack_resp_t r;
		int top_idx;
		mts_word_t tmp;
		r.val = '0;
		r.st = ST_OK;
		case (c.op)
			OP_PUSH: begin
				if (shadow_fill >= DEPTH)
					r.st = ST_OVER;
				else begin
					shadow_vals[shadow_fill] = c.val;
					shadow_fill++;
				end
			end
			OP_POP: begin
				if (shadow_fill == 0)
					r.st = ST_UNDER;
				else begin
					shadow_fill--;
					r.val = shadow_vals[shadow_fill];
				end
			end
			OP_EXTRACT: begin
				if (shadow_fill == 0)
					r.st = ST_UNDER;
				else begin
					// The topmost of equal maximums wins, so compare with >= going up.
					top_idx = 0;
					for (int i = 1; i < shadow_fill; i++)
						if (shadow_vals[i] >= shadow_vals[top_idx])
							top_idx = i;
					r.val = shadow_vals[top_idx];
					for (int i = top_idx; i + 1 < shadow_fill; i++)
						shadow_vals[i] = shadow_vals[i + 1];
					shadow_fill--;
				end
			end
			default: begin
				for (int i = 1; i < shadow_fill; i++)
					for (int j = i; j > 0 && shadow_vals[j] > shadow_vals[j - 1]; j--) begin
						tmp = shadow_vals[j];
						shadow_vals[j] = shadow_vals[j - 1];
						shadow_vals[j - 1] = tmp;
					end
			end
		endcase
		r.empty = (shadow_fill == 0);
		r.held = shadow_fill[8:0];
		return r;
	endfunction

	function automatic mts_word_t rand_word();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return mts_word_t'($urandom_range(0, 6)) - 3;
			default: return mts_word_t'($urandom);
		endcase
	endfunction

	task automatic add_cmd(mts_op_t op, mts_word_t v);
		stack_cmd_t c;
		c.op = op;
		c.val = v;
		pending_cmds.push_back(c);
		if (op == OP_PUSH && sim_fill < DEPTH)
			sim_fill++;
		else if ((op == OP_POP || op == OP_EXTRACT) && sim_fill > 0)
			sim_fill--;
	endtask

	initial begin
		int mode;
		sim_fill = 0;
		// Directed: empty-stack errors, extremes, equal maximums, sort.
		add_cmd(OP_POP, 32'sd5);
		add_cmd(OP_EXTRACT, 32'sd0);
		add_cmd(OP_SORT, 32'sd0);
		add_cmd(OP_PUSH, 32'sh80000000);
		add_cmd(OP_PUSH, 32'sh7fffffff);
		add_cmd(OP_PUSH, 32'sd0);
		add_cmd(OP_PUSH, 32'sh7fffffff);
		add_cmd(OP_PUSH, -32'sd1);
		add_cmd(OP_EXTRACT, 32'sd0);
		add_cmd(OP_PUSH, 32'sh55555555);
		add_cmd(OP_PUSH, 32'shaaaaaaaa);
		add_cmd(OP_SORT, 32'sd0);
		add_cmd(OP_POP, 32'sd0);
		add_cmd(OP_EXTRACT, 32'sd0);
		add_cmd(OP_EXTRACT, 32'sd0);
		add_cmd(OP_POP, 32'sd0);
		add_cmd(OP_POP, 32'sd0);
		add_cmd(OP_POP, 32'sd0);
		add_cmd(OP_POP, 32'sd0);
		// Fill to full once to reach overflow and the 256 entry count.
		for (int i = 0; i < DEPTH + 2; i++)
			add_cmd(OP_PUSH, rand_word());
		add_cmd(OP_EXTRACT, 32'sd0);
		add_cmd(OP_PUSH, 32'sd1);
		add_cmd(OP_PUSH, 32'sd2);
		for (int i = 0; i < DEPTH; i++)
			add_cmd(OP_POP, 32'sd0);
		// Random part: mostly small stacks so sorts stay cheap.
		while (pending_cmds.size() < 1250) begin
			mode = $urandom_range(0, 99);
			if (mode < 45 || sim_fill == 0 && mode < 60)
				add_cmd(OP_PUSH, rand_word());
			else if (mode < 65)
				add_cmd(OP_POP, rand_word());
			else if (mode < 90)
				add_cmd(OP_EXTRACT, rand_word());
			else if (sim_fill <= 24)
				add_cmd(OP_SORT, rand_word());
			else
				add_cmd(OP_POP, rand_word());
			if (sim_fill > 30)
				add_cmd(OP_EXTRACT, rand_word());
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = '0;
		push_value = '0;
		out_ready = 1'b0;
		shadow_fill = 0;
		mismatches = 0;
		idle_cycles = 0;
		gap_in = 0;
		gap_out = 0;
		in_count = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Driver: after an accepted beat, valid is dropped and the next one is loaded after a random gap.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready_seen) begin
				in_valid <= 1'b0;
				gap_in <= pick_gap();
			end else if (!in_valid) begin
				if (gap_in > 0)
					gap_in <= gap_in - 1;
				else if (pending_cmds.size() > 0) begin
					stack_cmd_t c;
					c = pending_cmds.pop_front();
					opcode <= c.op;
					push_value <= c.val;
					in_valid <= 1'b1;
				end
			end
			if (gap_out > 0) begin
				out_ready <= 1'b0;
				gap_out <= gap_out - 1;
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				gap_out <= pick_gap();
			end else
				out_ready <= 1'b1;
		end
	end

	// Monitor: predicts at input acceptance, checks at output acceptance.
	always @(posedge clk or negedge arst_n) begin
		stack_cmd_t  c;
		stack_resp_t exp_r;
		if (!arst_n)
			in_ready_seen <= 1'b0;
		else begin
			in_ready_seen <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				c.op = mts_op_t'(opcode);
				c.val = push_value;
				expected_resps.push_back(apply_stack_op(c));
				in_count++;
			end
			if (out_valid && out_ready) begin
				if (expected_resps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result beat: value %0d status %0d",
							result_value, status);
				end else begin
					exp_r = expected_resps.pop_front();
					if (result_value !== exp_r.val || stack_empty !== exp_r.empty ||
						status !== exp_r.st || entries_held !== exp_r.held) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: exp %0d/%0b/%0d/%0d got %0d/%0b/%0d/%0d",
								exp_r.val, exp_r.empty, exp_r.st, exp_r.held,
								result_value, stack_empty, status, entries_held);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (arst_n);
		while (!(pending_cmds.size() == 0 && !in_valid && expected_resps.size() == 0)
			&& idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			repeat (50) @(posedge clk);
			if (mismatches == 0)
				$display("Verification passed");
			else
				$display("Verification failed");
			$finish;
		end
	end

endmodule

### filelist.f
rtl/core/mts_pkg.sv
rtl/core/mts_ram.sv
rtl/core/max_tracking_stack.sv
tb/tb_max_tracking_stack.sv
